// ----- hw/rtl/chm_pkg.sv -----
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants and the key mix function for the chained hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

  // result status codes
  localparam logic [1:0] ST_PUT_OK   = 2'd0;
  localparam logic [1:0] ST_PUT_FULL = 2'd1;
  localparam logic [1:0] ST_GET_HIT  = 2'd2;
  localparam logic [1:0] ST_GET_MISS = 2'd3;

  // operation codes
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  // shift-add-xor mix of the key, before the final multiply
  function automatic logic [31:0] mix32(input logic [31:0] k);
    logic [31:0] h;
    h = k;
    h = h + (h << 12);
    h = h ^ (h >> 22);
    h = h + (h << 4);
    h = h ^ (h >> 9);
    h = h + (h << 10);
    h = h ^ (h >> 2);
    h = h + (h << 7);
    h = h ^ (h >> 12);
    return h;
  endfunction

endpackage

// ----- hw/rtl/chm_ram.sv -----
// ----------------------------------------------------------------------------
// chm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/chm_front.sv -----
// ----------------------------------------------------------------------------
// chm_front
// Accepts operations, computes the bucket index (mix, multiply, and a
// serial restoring modulo by the bucket count), and pushes the classified
// transaction into a small queue toward the back end.
// ----------------------------------------------------------------------------
module chm_front #(
  parameter int NUM_BUCKETS = 256,
  parameter int VALUE_BITS  = 32,
  parameter int QDEPTH      = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_opcode,
  input  logic [31:0]                    in_key,
  input  logic [31:0]                    in_write_value,
  input  logic [8:0]                     bucket_count,
  input  logic                           q_pop,
  output logic                           q_empty,
  output logic                           q_opcode,
  output logic [31:0]                    q_key,
  output logic [VALUE_BITS-1:0]          q_value,
  output logic [$clog2(NUM_BUCKETS)-1:0] q_bucket
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int DW = (BW + 1 > 9) ? BW + 1 : 9;
  localparam int QW = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t                state_r, state_nxt;
  logic                   op_r;
  logic [31:0]            key_r;
  logic [VALUE_BITS-1:0]  val_r;
  logic [31:0]            h_r;
  logic [DW-1:0]          div_r;
  logic [DW-1:0]          rem_r;
  logic [5:0]             cnt_r;

  // divisor after clamping to 1..NUM_BUCKETS
  logic [DW-1:0] bc_ext, div_eff;
  assign bc_ext  = DW'(bucket_count);
  always_comb begin
    div_eff = bc_ext;
    if (bc_ext == '0) div_eff = DW'(1);
    if (bc_ext > DW'(NUM_BUCKETS)) div_eff = DW'(NUM_BUCKETS);
  end

  // queue storage
  logic                  qop   [QDEPTH];
  logic [31:0]           qkey  [QDEPTH];
  logic [VALUE_BITS-1:0] qval  [QDEPTH];
  logic [BW-1:0]         qbkt  [QDEPTH];
  logic [QW-1:0]         wp_r, rp_r;
  logic [QW:0]           cnt_q_r;
  logic                  q_full, q_push;

  assign q_full  = (cnt_q_r == (QW+1)'(QDEPTH));
  assign q_empty = (cnt_q_r == '0);
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign in_full = (state_r != F_IDLE);

  // one restoring step of the modulo
  logic [DW:0] rem_sh;
  assign rem_sh = {rem_r, h_r[31]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_push) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_DIV;
      F_DIV:  if (cnt_r == 6'd31) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_q_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_push) wp_r <= (wp_r == QW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_pop && !q_empty) rp_r <= (rp_r == QW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_q_r <= cnt_q_r + (QW+1)'(q_push) - (QW+1)'(q_pop && !q_empty);
    end
  end

  // datapath: hash, multiply, bit-serial modulo
  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (in_push) begin
          op_r  <= in_opcode;
          key_r <= in_key;
          val_r <= in_write_value[VALUE_BITS-1:0];
          h_r   <= chm_pkg::mix32(in_key) >> 3;
        end
      end
      F_MUL: begin
        h_r   <= h_r * chm_pkg::HASH_MULT;
        div_r <= div_eff;
        rem_r <= '0;
        cnt_r <= '0;
      end
      F_DIV: begin
        h_r   <= h_r << 1;
        cnt_r <= cnt_r + 6'd1;
        if (rem_sh >= {1'b0, div_r}) rem_r <= DW'(rem_sh - {1'b0, div_r});
        else                         rem_r <= rem_sh[DW-1:0];
      end
      default: ;
    endcase
    if (q_push) begin
      qop[wp_r]  <= op_r;
      qkey[wp_r] <= key_r;
      qval[wp_r] <= val_r;
      qbkt[wp_r] <= rem_r[BW-1:0];
    end
  end

  assign q_opcode = qop[rp_r];
  assign q_key    = qkey[rp_r];
  assign q_value  = qval[rp_r];
  assign q_bucket = qbkt[rp_r];

endmodule

// ----- hw/rtl/chm_back.sv -----
// ----------------------------------------------------------------------------
// chm_back
// Walks a bucket chain in the entry memories, applies the put or get, and
// places the result in a single output register.
// ----------------------------------------------------------------------------
module chm_back #(
  parameter int NUM_BUCKETS  = 256,
  parameter int POOL_ENTRIES = 256,
  parameter int VALUE_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic                           q_opcode,
  input  logic [31:0]                    q_key,
  input  logic [VALUE_BITS-1:0]          q_value,
  input  logic [$clog2(NUM_BUCKETS)-1:0] q_bucket,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [1:0]                     out_status,
  output logic [31:0]                    out_read_value
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int EW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int PD = 1 << EW;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_HEAD = 6'b000010,
    B_READ = 6'b000100,
    B_CMP  = 6'b001000,
    B_DONE = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_t;

  bstate_t               state_r, state_nxt;
  logic [NUM_BUCKETS-1:0] hvalid_r;
  logic [EW:0]           used_r;
  logic [EW:0]           steps_r;
  logic                  op_r;
  logic [31:0]           key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [BW-1:0]         bkt_r;
  logic [EW-1:0]         idx_r;
  logic                  found_r;
  logic                  ovalid_r;
  logic [1:0]            ostat_r;
  logic [31:0]           oval_r;
  logic [1:0]            res_stat_r;
  logic [31:0]           res_val_r;

  // memories
  logic          head_we, key_we, val_we, lnk_we;
  logic [EW-1:0] head_rd, head_wd;
  logic [BW-1:0] head_raddr;
  logic [31:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd, val_wd;
  logic [EW:0]   lnk_rd, lnk_wd;
  logic [EW-1:0] ent_waddr, newe;

  assign newe = used_r[EW-1:0];

  // head read starts while the transaction is popped, so it is ready in B_HEAD
  assign head_raddr = (state_r == B_IDLE) ? q_bucket : bkt_r;

  chm_ram #(.WIDTH(EW), .DEPTH(NUM_BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .waddr(bkt_r), .wdata(head_wd),
    .raddr(head_raddr), .rdata(head_rd));
  chm_ram #(.WIDTH(32), .DEPTH(PD)) u_keys (
    .clk(clk), .we(key_we), .waddr(ent_waddr), .wdata(key_r),
    .raddr(idx_r), .rdata(key_rd));
  chm_ram #(.WIDTH(VALUE_BITS), .DEPTH(PD)) u_vals (
    .clk(clk), .we(val_we), .waddr(ent_waddr), .wdata(val_wd),
    .raddr(idx_r), .rdata(val_rd));
  chm_ram #(.WIDTH(EW + 1), .DEPTH(PD)) u_links (
    .clk(clk), .we(lnk_we), .waddr(ent_waddr), .wdata(lnk_wd),
    .raddr(idx_r), .rdata(lnk_rd));

  logic pool_full, hit;
  assign pool_full = (used_r >= (EW+1)'(POOL_ENTRIES));
  assign hit       = (key_rd == key_r);

  // writes at the end of the walk
  always_comb begin
    head_we   = 1'b0;
    key_we    = 1'b0;
    val_we    = 1'b0;
    lnk_we    = 1'b0;
    head_wd   = newe;
    val_wd    = val_r;
    lnk_wd    = {hvalid_r[bkt_r], head_rd};
    ent_waddr = newe;
    if (state_r == B_DONE && op_r == chm_pkg::OP_PUT) begin
      if (found_r) begin
        val_we    = 1'b1;
        ent_waddr = idx_r;
      end else if (!pool_full) begin
        head_we = 1'b1;
        key_we  = 1'b1;
        val_we  = 1'b1;
        lnk_we  = 1'b1;
      end
    end
  end

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_HEAD;
      B_HEAD: state_nxt = hvalid_r[bkt_r] ? B_READ : B_DONE;
      B_READ: state_nxt = B_CMP;
      B_CMP: begin
        if (hit || !lnk_rd[EW] || steps_r == (EW+1)'(POOL_ENTRIES - 1)) state_nxt = B_DONE;
        else state_nxt = B_READ;
      end
      B_DONE: state_nxt = B_OUT;
      B_OUT:  if (!ovalid_r) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      hvalid_r <= '0;
      used_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (head_we) begin
        hvalid_r[bkt_r] <= 1'b1;
        used_r <= used_r + 1'b1;
      end
      if (state_r == B_OUT && !ovalid_r) ovalid_r <= 1'b1;
      else if (out_pop && ovalid_r) ovalid_r <= 1'b0;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        op_r  <= q_opcode;
        key_r <= q_key;
        val_r <= q_value;
        bkt_r <= q_bucket;
      end
      B_HEAD: begin
        idx_r   <= head_rd;
        found_r <= 1'b0;
        steps_r <= '0;
      end
      B_CMP: begin
        if (hit) found_r <= 1'b1;
        else begin
          idx_r   <= lnk_rd[EW-1:0];
          steps_r <= steps_r + 1'b1;
        end
      end
      B_DONE: begin
        if (op_r == chm_pkg::OP_PUT) begin
          res_stat_r <= (found_r || !pool_full) ? chm_pkg::ST_PUT_OK : chm_pkg::ST_PUT_FULL;
          res_val_r  <= '0;
        end else if (found_r) begin
          res_stat_r <= chm_pkg::ST_GET_HIT;
          res_val_r  <= 32'(val_rd);
        end else begin
          res_stat_r <= chm_pkg::ST_GET_MISS;
          res_val_r  <= '0;
        end
      end
      // load the output register once the previous result has left
      B_OUT: begin
        if (!ovalid_r) begin
          ostat_r <= res_stat_r;
          oval_r  <= res_val_r;
        end
      end
      default: ;
    endcase
  end

  assign out_empty      = !ovalid_r;
  assign out_status     = ostat_r;
  assign out_read_value = oval_r;

endmodule

// ----- hw/rtl/chained_hash_map_engine.sv -----
// Each input is mixed on accept, multiplied, and reduced by a 32-step bucket
// modulo in the front; the back then walks the bucket chain entry by entry.
// The front takes no new input until its current one is queued, and a
// two-entry queue lets the front and the back walk overlap.
// Reset (rst_n, synchronous, active low) empties all buckets and the pool
// and sets bucket_count to 256.
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Hash map with chained buckets: put/get on 32-bit keys over a fixed pool.
// ----------------------------------------------------------------------------
module chained_hash_map_engine #(
  parameter int NUM_BUCKETS  = 256,
  parameter int POOL_ENTRIES = 256,
  parameter int VALUE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_write_value,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_bucket_count
);

  localparam int BW = $clog2(NUM_BUCKETS);

  logic [8:0] bucket_count_r;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= 9'd256;
    else if (cfg_valid) bucket_count_r <= cfg_bucket_count;
  end

  logic                  q_pop, q_empty, q_opcode;
  logic [31:0]           q_key;
  logic [VALUE_BITS-1:0] q_value;
  logic [BW-1:0]         q_bucket;

  chm_front #(.NUM_BUCKETS(NUM_BUCKETS), .VALUE_BITS(VALUE_BITS), .QDEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(push), .in_full(full),
    .in_opcode(in_opcode), .in_key(in_key), .in_write_value(in_write_value),
    .bucket_count(bucket_count_r), .q_pop(q_pop), .q_empty(q_empty),
    .q_opcode(q_opcode), .q_key(q_key), .q_value(q_value), .q_bucket(q_bucket));

  chm_back #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES),
    .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_pop(q_pop),
    .q_opcode(q_opcode), .q_key(q_key), .q_value(q_value), .q_bucket(q_bucket),
    .out_empty(empty), .out_pop(pop), .out_status(out_status),
    .out_read_value(out_read_value));

endmodule
